// ===== sv/bpe_pkg.sv =====
// Shared types and constants for the bivariate polynomial evaluator.
// No dependencies; used by the core and its port checker.
`default_nettype none

package bpe_pkg;

	localparam int Q_W       = 48;  // Q16.32 coefficient and result
	localparam int XY_W      = 32;  // Q2.30 variables
	localparam int FRAC      = 30;  // fraction bits of x, y and monomials
	localparam int IDX_W     = 6;
	localparam int ORD_W     = 4;
	localparam int HALF_W    = 24;  // limb width of the shared multiplier
	localparam int PP_W      = 2 * (HALF_W + 1);
	localparam int ACC_W     = 2 * Q_W;
	localparam int S_TDATA_W = 120;
	localparam int M_TDATA_W = 48;

	localparam logic signed [Q_W-1:0] Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic signed [Q_W-1:0] ONE_Q30 = Q_W'(1) << FRAC;
	localparam logic [ACC_W-1:0]      RND_INIT = ACC_W'(1) << (FRAC - 1);

	// product in flight on the shared multiplier
	typedef enum logic [1:0] {
		OP_TERM = 2'd0,  // coefficient times monomial
		OP_MONO = 2'd1,  // monomial times y
		OP_XPOW = 2'd2   // x power times x
	} op_t;

endpackage

`default_nettype wire

// ===== sv/bpe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpe_ram #(
	parameter int W     = 48,
	parameter int DEPTH = 55,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/bivariate_polynomial_eval_core.sv =====
// Evaluate item: T = (ord+1)(ord+2)/2 terms; per term a coefficient read, a term product and,
// but for the last term, a monomial or x-power product, each on the shared 25x25 multiplier in
// four limb passes plus a drain; the next item can transfer once the result is handed on.
// Load item: written straight into the coefficient RAM; the next item follows at once.
// One item in flight; a finished result waits in the output register (held back while it is full).
// arst_n clears control state and the order register; the coefficient RAM is not cleared.
`default_nettype none

module bivariate_polynomial_eval_core #(
	parameter int MAX_ORDER = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// order register write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data,     // poly_order
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [119:0] s_tdata,     // coef_index[5:0], coef_value[53:6],
	                                       // x_in[85:54], y_in[117:86], zero pad
	input  wire logic [0:0]  s_tuser,      // action (0 load, 1 evaluate)
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,      // value[47:0]
	output logic [0:0]       m_tuser       // saturated
);

	localparam int NTERMS = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2;
	localparam int AW     = (NTERMS > 1) ? $clog2(NTERMS) : 1;
	localparam int QW     = bpe_pkg::Q_W;
	localparam int XW     = bpe_pkg::XY_W;
	localparam int HW     = bpe_pkg::HALF_W;
	localparam int AC     = bpe_pkg::ACC_W;
	localparam int FR     = bpe_pkg::FRAC;

	typedef enum logic [2:0] {
		ST_IDLE,   // take loads and evaluates
		ST_RD,     // coefficient read in flight
		ST_CF,     // coefficient on RAM output, launch term product
		ST_MUL,    // four limb passes plus drain
		ST_FIN,    // round, saturate, accumulate, pick next product
		ST_DONE    // hand result to output register
	} state_t;

	state_t state_q, state_d;

	// ---------------- input field unpack ----------------
	logic [bpe_pkg::IDX_W-1:0]   in_idx;
	logic [QW-1:0]               in_coef;
	logic [XW-1:0]               in_x, in_y;
	logic                        in_eval;
	logic                        s_xfer;

	assign in_idx  = s_tdata[5:0];
	assign in_coef = s_tdata[53:6];
	assign in_x    = s_tdata[85:54];
	assign in_y    = s_tdata[117:86];
	assign in_eval = s_tuser[0];

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// ---------------- coefficient store ----------------
	// Loads go straight to the write port; evaluates only read, so the two never
	// touch the same entry in one cycle. Out-of-range loads are dropped.
	logic          ram_we;
	logic [QW-1:0] ram_rdata;
	logic [AW-1:0] k_q;

	assign ram_we = s_xfer && !in_eval && (32'(in_idx) < 32'(NTERMS));

	bpe_ram #(
		.W     (QW),
		.DEPTH (NTERMS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_idx)),
		.wdata (in_coef),
		.raddr (k_q),
		.rdata (ram_rdata)
	);

	// ---------------- evaluation state ----------------
	logic [3:0]      poly_order_q;
	logic [3:0]      ord_q, i_q, j_q;
	logic [XW-1:0]   x_q, y_q;
	logic [QW-1:0]   xp_q, m_q, sum_q;
	logic            sat_q;
	bpe_pkg::op_t    op_q;

	// shared multiplier: operands, pass counter, limb product, accumulator
	logic [QW-1:0]          opa_q, opb_q;
	logic [2:0]             mc_q;
	logic signed [bpe_pkg::PP_W-1:0] pp_s1;
	logic [1:0]             sh_s1;
	logic [AC-1:0]          acc_q;

	logic signed [HW:0]     mul_a, mul_b;
	logic [AC-1:0]          pp_ext, pp_shl;

	// pass 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi; low limbs unsigned, high limbs signed
	assign mul_a = mc_q[1] ? {opa_q[QW-1], opa_q[QW-1:HW]} : {1'b0, opa_q[HW-1:0]};
	assign mul_b = mc_q[0] ? {opb_q[QW-1], opb_q[QW-1:HW]} : {1'b0, opb_q[HW-1:0]};

	assign pp_ext = {{(AC - bpe_pkg::PP_W){pp_s1[bpe_pkg::PP_W-1]}}, pp_s1};

	always_comb begin
		case (sh_s1)
			2'd0:    pp_shl = pp_ext;
			2'd1:    pp_shl = {pp_ext[AC-HW-1:0], {HW{1'b0}}};
			2'd2:    pp_shl = {pp_ext[AC-2*HW-1:0], {(2*HW){1'b0}}};
			default: pp_shl = pp_ext;
		endcase
	end

	// Round and saturate the finished product: the accumulator was seeded with
	// half an LSB, so dropping the fraction rounds to nearest, ties up.
	logic [AC-FR-1:0] rnd;
	logic             prod_fits, prod_ovf;
	logic [QW-1:0]    prod_res;

	assign rnd       = acc_q[AC-1:FR];
	assign prod_fits = (&rnd[AC-FR-1:QW-1]) || !(|rnd[AC-FR-1:QW-1]);
	assign prod_ovf  = !prod_fits;
	assign prod_res  = prod_fits ? rnd[QW-1:0] : (acc_q[AC-1] ? bpe_pkg::Q_MIN : bpe_pkg::Q_MAX);

	// saturating running sum
	logic [QW:0]   sum_wide;
	logic          sum_ovf;
	logic [QW-1:0] sum_next;

	assign sum_wide = {sum_q[QW-1], sum_q} + {prod_res[QW-1], prod_res};
	assign sum_ovf  = sum_wide[QW] != sum_wide[QW-1];
	assign sum_next = sum_ovf ? (sum_wide[QW] ? bpe_pkg::Q_MIN : bpe_pkg::Q_MAX)
	                          : sum_wide[QW-1:0];

	// term walk: j runs while i+j stays below the order, then i advances
	logic row_more, col_more;
	assign row_more = (5'(i_q) + 5'(j_q)) < 5'(ord_q);
	assign col_more = i_q < ord_q;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_xfer && in_eval) begin
					state_d = ST_RD;
				end
			end
			ST_RD:  state_d = ST_CF;
			ST_CF:  state_d = ST_MUL;
			ST_MUL: begin
				if (mc_q == 3'd4) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				case (op_q)
					bpe_pkg::OP_TERM: state_d = (row_more || col_more) ? ST_MUL : ST_DONE;
					default:          state_d = ST_RD;
				endcase
			end
			ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- control and registered outputs ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mc_q         <= 3'd0;
			poly_order_q <= 4'd0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
		end else begin
			state_q <= state_d;
			mc_q    <= (state_q == ST_MUL) ? mc_q + 3'd1 : 3'd0;
			if (cfg_valid && cfg_ready) begin
				poly_order_q <= cfg_data;
			end
			// hold the result until its transfer; refill in the same cycle
			if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
				m_tvalid   <= 1'b1;
				m_tdata    <= sum_q;
				m_tuser[0] <= sat_q;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		// limb product registered before it reaches the accumulator
		pp_s1 <= mul_a * mul_b;
		sh_s1 <= 2'(mc_q[1]) + 2'(mc_q[0]);

		case (state_q)
			ST_IDLE: begin
				if (s_xfer && in_eval) begin
					x_q   <= in_x;
					y_q   <= in_y;
					ord_q <= (poly_order_q > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : poly_order_q;
					i_q   <= 4'd0;
					j_q   <= 4'd0;
					k_q   <= '0;
					xp_q  <= bpe_pkg::ONE_Q30;
					m_q   <= bpe_pkg::ONE_Q30;
					sum_q <= '0;
					sat_q <= 1'b0;
				end
			end
			ST_CF: begin
				opa_q <= ram_rdata;
				opb_q <= m_q;
				op_q  <= bpe_pkg::OP_TERM;
				acc_q <= bpe_pkg::RND_INIT;
			end
			ST_MUL: begin
				// pass 0 result lands in the cycle after issue
				if (mc_q != 3'd0) begin
					acc_q <= acc_q + pp_shl;
				end
			end
			ST_FIN: begin
				case (op_q)
					bpe_pkg::OP_TERM: begin
						sum_q <= sum_next;
						sat_q <= sat_q | prod_ovf | sum_ovf;
						k_q   <= k_q + AW'(1);
						acc_q <= bpe_pkg::RND_INIT;
						if (row_more) begin
							opa_q <= m_q;
							opb_q <= {{(QW-XW){y_q[XW-1]}}, y_q};
							op_q  <= bpe_pkg::OP_MONO;
						end else begin
							opa_q <= xp_q;
							opb_q <= {{(QW-XW){x_q[XW-1]}}, x_q};
							op_q  <= bpe_pkg::OP_XPOW;
						end
					end
					bpe_pkg::OP_MONO: begin
						m_q   <= prod_res;
						j_q   <= j_q + 4'd1;
						sat_q <= sat_q | prod_ovf;
					end
					bpe_pkg::OP_XPOW: begin
						xp_q  <= prod_res;
						m_q   <= prod_res;
						i_q   <= i_q + 4'd1;
						j_q   <= 4'd0;
						sat_q <= sat_q | prod_ovf;
					end
					default: begin
						sat_q <= sat_q;
					end
				endcase
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/bpe_chk.sv =====
// Port-level checker for bivariate_polynomial_eval_core, attached by bind.
// Depends on bpe_pkg.
`default_nettype none

module bpe_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [bpe_pkg::S_TDATA_W-1:0]   s_tdata,
	input wire logic [0:0]                      s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [bpe_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire logic [0:0]                      m_tuser
);

	logic s_xfer;
	assign s_xfer = s_tvalid && s_tready;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an evaluate keeps the core busy in the cycle after its transfer
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && s_tuser[0] |=> !s_tready)
		else $error("input taken right after an evaluate");

	// a load never blocks the next item
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && !s_tuser[0] |=> s_tready)
		else $error("load stalled the input");

	// a fresh result appears only as the core returns to idle
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result raised while core busy");

endmodule

bind bivariate_polynomial_eval_core bpe_chk u_bpe_chk (.*);

`default_nettype wire
